[hdl/hhc_pkg.sv]
package hhc_pkg;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned BAND_W   = 5;
  localparam int unsigned SERVO_W  = 10;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CADDR_W  = 2;
  localparam int unsigned CDATA_W  = 7;
  // raw * 100 and pct * 65535 both fit in 23 bits
  localparam int unsigned SCALED_W = 23;

  localparam logic [SCALED_W-1:0] PCT_FULL = SCALED_W'(100);
  localparam logic [SCALED_W-1:0] RAW_FULL = SCALED_W'(65535);

  localparam logic [SERVO_W-1:0] SERVO_OPEN   = SERVO_W'(270);
  localparam logic [SERVO_W-1:0] SERVO_CLOSED = SERVO_W'(545);

  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(4);

  localparam logic ACT_CONTROL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef enum logic [CADDR_W-1:0] {
    CFG_SHUTTER  = 2'd0,
    CFG_FAN_LOW  = 2'd1,
    CFG_FAN_HIGH = 2'd2,
    CFG_BAND     = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [PCT_W-1:0]  shutter_thr;
    logic [PCT_W-1:0]  fan_low_thr;
    logic [PCT_W-1:0]  fan_high_thr;
    logic [BAND_W-1:0] band;
  } cfg_regs_t;

  typedef struct packed {
    logic shutter_above;
    logic fan_low_above;
    logic fan_high_above;
    logic fan_low_below;
    logic shutter_below;
  } cmp_flags_t;

  localparam logic [PCT_W-1:0]  SHUTTER_RST  = PCT_W'(50);
  localparam logic [PCT_W-1:0]  FAN_LOW_RST  = PCT_W'(60);
  localparam logic [PCT_W-1:0]  FAN_HIGH_RST = PCT_W'(70);
  localparam logic [BAND_W-1:0] BAND_RST     = BAND_W'(5);

endpackage

[hdl/hhc_in_if.sv]
interface hhc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [hhc_pkg::RAW_W-1:0]      humidity_raw;

  modport source (output valid, output action, output humidity_raw, input ready);
  modport sink   (input valid, input action, input humidity_raw, output ready);
endinterface

[hdl/hhc_out_if.sv]
interface hhc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           shutter_is_open;
  logic [hhc_pkg::SERVO_W-1:0]    servo_compare;
  logic [hhc_pkg::LEVEL_W-1:0]    fan_drive_level;
  logic                           fan_pin;

  modport source (output valid, output shutter_is_open, output servo_compare,
                  output fan_drive_level, output fan_pin, input ready);
  modport sink   (input valid, input shutter_is_open, input servo_compare,
                  input fan_drive_level, input fan_pin, output ready);
endinterface

[hdl/hhc_cfg_if.sv]
interface hhc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hhc_pkg::CADDR_W-1:0]    addr;
  logic [hhc_pkg::CDATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[hdl/hhc_cmp.sv]
module hhc_cmp (
  input  logic [hhc_pkg::RAW_W-1:0] raw,
  input  hhc_pkg::cfg_regs_t        cfg,
  output hhc_pkg::cmp_flags_t       flags
);
  import hhc_pkg::*;

  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] sh_lim;
  logic [SCALED_W-1:0] fl_lim;
  logic [SCALED_W-1:0] fh_lim;
  logic [PCT_W:0]      sh_low;
  logic [PCT_W:0]      fl_low;
  logic [SCALED_W-1:0] sh_low_lim;
  logic [SCALED_W-1:0] fl_low_lim;

  // exact percent compare: raw*100 against pct*65535
  assign scaled = SCALED_W'(raw) * PCT_FULL;
  assign sh_lim = SCALED_W'(cfg.shutter_thr) * RAW_FULL;
  assign fl_lim = SCALED_W'(cfg.fan_low_thr) * RAW_FULL;
  assign fh_lim = SCALED_W'(cfg.fan_high_thr) * RAW_FULL;

  // lower bounds; the top bit flags a negative difference
  assign sh_low = {1'b0, cfg.shutter_thr} - (PCT_W+1)'(cfg.band);
  assign fl_low = {1'b0, cfg.fan_low_thr} - (PCT_W+1)'(cfg.band);
  assign sh_low_lim = SCALED_W'(sh_low[PCT_W-1:0]) * RAW_FULL;
  assign fl_low_lim = SCALED_W'(fl_low[PCT_W-1:0]) * RAW_FULL;

  always_comb begin
    flags.shutter_above  = scaled > sh_lim;
    flags.fan_low_above  = scaled > fl_lim;
    flags.fan_high_above = scaled > fh_lim;
    flags.fan_low_below  = !fl_low[PCT_W] && (scaled < fl_low_lim);
    flags.shutter_below  = !sh_low[PCT_W] && (scaled < sh_low_lim);
  end

endmodule

[hdl/hhc_core.sv]
module hhc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  hhc_in_if.sink                    in_ch,
  hhc_out_if.source                 out_ch,
  output logic [hhc_pkg::RAW_W-1:0] s1_raw,
  input  hhc_pkg::cmp_flags_t       flags
);
  import hhc_pkg::*;

  logic                s1_valid_r;
  logic                s1_action_r;
  logic [RAW_W-1:0]    s1_raw_r;

  logic                out_valid_r;
  logic                out_open_r;
  logic [SERVO_W-1:0]  out_servo_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic                out_pin_r;

  logic                open_r, open_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                pin_r, pin_nxt;

  logic                s2_adv;
  logic                s1_take;

  assign s2_adv  = !out_valid_r || out_ch.ready;
  assign s1_take = !s1_valid_r || s2_adv;

  assign in_ch.ready = s1_take;
  assign s1_raw      = s1_raw_r;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.shutter_is_open = out_open_r;
  assign out_ch.servo_compare   = out_servo_r;
  assign out_ch.fan_drive_level = out_level_r;
  assign out_ch.fan_pin         = out_pin_r;

  always_comb begin
    open_nxt  = open_r;
    level_nxt = level_r;
    phase_nxt = phase_r;
    pin_nxt   = pin_r;
    if (s1_action_r == ACT_CONTROL) begin
      if (flags.shutter_above) begin
        open_nxt = 1'b1;
      end
      if (flags.fan_low_above) begin
        level_nxt = (level_r == LEVEL_OFF) ? LEVEL_FULL : LEVEL_HALF;
      end
      if (flags.fan_high_above) begin
        level_nxt = LEVEL_FULL;
      end
      if (flags.fan_low_below) begin
        level_nxt = LEVEL_OFF;
      end
      if (flags.shutter_below) begin
        open_nxt = 1'b0;
      end
    end else begin
      phase_nxt = phase_r + PHASE_W'(1);
      pin_nxt   = LEVEL_W'(phase_nxt) < level_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_ch.valid) begin
      s1_action_r <= in_ch.action;
      s1_raw_r    <= in_ch.humidity_raw;
    end
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
      level_r     <= LEVEL_OFF;
      phase_r     <= '0;
      pin_r       <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        open_r  <= open_nxt;
        level_r <= level_nxt;
        phase_r <= phase_nxt;
        pin_r   <= pin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_open_r  <= open_nxt;
      out_servo_r <= open_nxt ? SERVO_OPEN : SERVO_CLOSED;
      out_level_r <= level_nxt;
      out_pin_r   <= pin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == LEVEL_OFF) || (level_r == LEVEL_HALF) || (level_r == LEVEL_FULL))
    else $error("fan level left the legal set");

  a_servo_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_servo_r == (out_open_r ? SERVO_OPEN : SERVO_CLOSED)))
    else $error("servo compare disagrees with shutter state");

  a_tick_keeps_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s1_valid_r && (s1_action_r == ACT_TICK)) |=>
      (level_r == $past(level_r)) && (open_r == $past(open_r)))
    else $error("tick request changed shutter or fan level");

  a_ctrl_keeps_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s1_valid_r && (s1_action_r == ACT_CONTROL)) |=>
      (phase_r == $past(phase_r)) && (pin_r == $past(pin_r)))
    else $error("control request changed PWM phase or pin");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_adv && s1_valid_r) |=> $stable(level_r) && $stable(phase_r))
    else $error("state moved without a request");
`endif

endmodule

[hdl/humidity_hysteresis_controller_top.sv]
// Channel  Dir  Payload                                                  Handshake
// in_ch    in   action, humidity_raw                                     valid/ready
// out_ch   out  shutter_is_open, servo_compare, fan_drive_level, fan_pin valid/ready
// cfg_ch   in   addr (register index), data                              valid/ready
//
// Each request goes from acceptance into the input register, then through the
// threshold compare and state update into the result register. A new request
// can be accepted every clock while the output is not stalled.
// Reset (rst_n low, synchronous) clears both valid stages and the controller
// state and loads the threshold registers with their defaults.
// A stalled result holds the result register; the input register still
// takes a request while it is empty. cfg_ch is always ready.
module humidity_hysteresis_controller_top (
  input  logic      clk,
  input  logic      rst_n,
  hhc_in_if.sink    in_ch,
  hhc_out_if.source out_ch,
  hhc_cfg_if.sink   cfg_ch
);
  import hhc_pkg::*;

  cfg_regs_t        cfg_r;
  cmp_flags_t       flags;
  logic [RAW_W-1:0] s1_raw;

  // register writes go straight into the registers, so never stall the config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutter_thr  <= SHUTTER_RST;
      cfg_r.fan_low_thr  <= FAN_LOW_RST;
      cfg_r.fan_high_thr <= FAN_HIGH_RST;
      cfg_r.band         <= BAND_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_addr_t'(cfg_ch.addr))
        CFG_SHUTTER:  cfg_r.shutter_thr  <= cfg_ch.data;
        CFG_FAN_LOW:  cfg_r.fan_low_thr  <= cfg_ch.data;
        CFG_FAN_HIGH: cfg_r.fan_high_thr <= cfg_ch.data;
        CFG_BAND:     cfg_r.band         <= cfg_ch.data[BAND_W-1:0];
        default:      cfg_r              <= cfg_r;
      endcase
    end
  end

  // compare the registered sample against all thresholds at once
  hhc_cmp u_cmp (
    .raw   (s1_raw),
    .cfg   (cfg_r),
    .flags (flags)
  );

  // input register, hysteresis state, PWM counter and result register
  hhc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .s1_raw (s1_raw),
    .flags  (flags)
  );

endmodule

[bench/tb_humidity_hysteresis_controller_top.sv]
`timescale 1ns / 100ps

module tb_humidity_hysteresis_controller_top;
  import hhc_pkg::*;

  // One result as the block shows it after a request
  typedef struct packed {
    logic               shutter_is_open;
    logic [SERVO_W-1:0] servo_compare;
    logic [LEVEL_W-1:0] fan_drive_level;
    logic               fan_pin;
  } climate_view_t;

  // Controller state as the block keeps it
  typedef struct packed {
    logic               open;
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase;
    logic               pin;
  } climate_state_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed script: either a register write or a request,
  // with a hand-typed result where it is obvious
  typedef struct packed {
    row_kind_t          kind;
    cfg_addr_t          addr;
    logic [CDATA_W-1:0] data;
    logic               act;
    logic [RAW_W-1:0]   raw;
    logic               typed;
    climate_view_t      want;
  } script_row_t;

  localparam climate_view_t SHOW_IDLE      = '{1'b0, SERVO_CLOSED, LEVEL_OFF, 1'b0};
  localparam climate_view_t SHOW_FULL_OPEN = '{1'b1, SERVO_OPEN, LEVEL_FULL, 1'b0};
  localparam climate_view_t SHOW_NONE      = '0;

  localparam int SCRIPT_LEN     = 35;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 105;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_AFTER     = 400;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_MAX     = 10;

  // Directed script. Rows with typed results sit right after reset and at the
  // sample extremes; every other row is scored by the predictor.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // after reset: a tick leaves the pin low, the sample lines are ignored
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'hFFFF, 1'b1, SHOW_IDLE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0000, 1'b1, SHOW_IDLE},
    // full scale: shutter opens, startup pulse at full level
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'hFFFF, 1'b1, SHOW_FULL_OPEN},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'h5A5A, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'hA5A5, 1'b0, SHOW_NONE},
    // 65 percent: between fan thresholds, drop to half level
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd42598, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'h0000, 1'b0, SHOW_NONE},
    // exactly 60 percent is not above, one count more is
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd39321, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd39322, 1'b0, SHOW_NONE},
    // just under 55 percent stops the fan, then a restart pulse
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd36044, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd40000, 1'b0, SHOW_NONE},
    // just under 45 percent closes the shutter, just over 50 reopens it
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd29490, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'd32768, 1'b0, SHOW_NONE},
    // all thresholds and the band at zero
    '{ROW_CFG,  CFG_SHUTTER,  7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_FAN_LOW,  7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_FAN_HIGH, 7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_BAND,     7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0001, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'hFFFF, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    // thresholds beyond 100 percent and the band masked to its width
    '{ROW_CFG,  CFG_SHUTTER,  7'h7F, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_FAN_LOW,  7'h7F, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_FAN_HIGH, 7'h7F, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_BAND,     7'h7F, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'hFFFF, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    // lower bounds below zero: nothing closes or stops
    '{ROW_CFG,  CFG_SHUTTER,  7'd3,  ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_FAN_LOW,  7'd2,  ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_CFG,  CFG_BAND,     7'd10, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'hFFFF, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_CONTROL, 16'h0000, 1'b0, SHOW_NONE},
    '{ROW_ITEM, CFG_SHUTTER, 7'd0, ACT_TICK,    16'h0000, 1'b0, SHOW_NONE}
  };

  // Fixed settings for the first random phases: defaults, all zero, all at
  // 100 with a band of 19, all-ones, and bounds that go negative
  localparam cfg_regs_t FIXED_SETTINGS [5] = '{
    '{SHUTTER_RST, FAN_LOW_RST, FAN_HIGH_RST, BAND_RST},
    '{7'd0,   7'd0,   7'd0,   5'd0},
    '{7'd100, 7'd100, 7'd100, 5'd19},
    '{7'd127, 7'd127, 7'd127, 5'd31},
    '{7'd3,   7'd8,   7'd2,   5'd10}
  };

  logic clk = 1'b0;
  logic rst_n;

  hhc_in_if  in_ch ();
  hhc_out_if out_ch ();
  hhc_cfg_if cfg_ch ();

  humidity_hysteresis_controller_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers and the controller state
  cfg_regs_t      climate_cfg;
  climate_state_t climate;

  // Results the block owes, oldest first
  climate_view_t climate_due [$];

  int  results_seen    = 0;
  int  n_bad           = 0;
  int  n_samples       = 0;
  int  n_ticks         = 0;
  int  n_settings      = 0;
  int  n_startups      = 0;
  int  n_shutter_moves = 0;
  int  in_stall_cycles = 0;
  int  idle_cycles     = 0;
  int  burst_left      = 0;
  int  sweep_pct       = 40;
  int  sweep_dir       = 1;
  logic backlog_hold   = 1'b0;
  logic hold_done      = 1'b0;

  // Apply one request to the predictor and return what the block should show.
  // Percent compares are exact: raw * 100 against threshold * 65535, with
  // threshold minus band kept signed.
  function automatic climate_view_t advance_climate(input logic act,
                                                    input logic [RAW_W-1:0] raw);
    int scaled;
    int span;
    int ts;
    int fl;
    int fh;
    int hb;
    logic was_open;
    climate_view_t view;
    scaled   = int'(raw) * int'(PCT_FULL);
    span     = int'(RAW_FULL);
    ts       = int'(climate_cfg.shutter_thr);
    fl       = int'(climate_cfg.fan_low_thr);
    fh       = int'(climate_cfg.fan_high_thr);
    hb       = int'(climate_cfg.band);
    was_open = climate.open;
    if (act == ACT_CONTROL) begin
      n_samples++;
      if (scaled > ts * span) climate.open = 1'b1;
      if (scaled > fl * span) begin
        if (climate.level == LEVEL_OFF) n_startups++;
        climate.level = (climate.level == LEVEL_OFF) ? LEVEL_FULL : LEVEL_HALF;
      end
      if (scaled > fh * span) climate.level = LEVEL_FULL;
      if (scaled < (fl - hb) * span) climate.level = LEVEL_OFF;
      if (scaled < (ts - hb) * span) climate.open = 1'b0;
      if (climate.open != was_open) n_shutter_moves++;
    end else begin
      n_ticks++;
      climate.phase = climate.phase + 1'b1;
      climate.pin   = ({1'b0, climate.phase} < climate.level);
    end
    view.shutter_is_open = climate.open;
    view.servo_compare   = climate.open ? SERVO_OPEN : SERVO_CLOSED;
    view.fan_drive_level = climate.level;
    view.fan_pin         = climate.pin;
    return view;
  endfunction

  // Raw sample for a percent value, nudged and clamped to the field
  function automatic logic [RAW_W-1:0] pct_to_raw(input int pct, input int nudge);
    int r;
    r = pct * int'(RAW_FULL) / int'(PCT_FULL) + nudge;
    if (r < 0) r = 0;
    else if (r > int'(RAW_FULL)) r = int'(RAW_FULL);
    return r[RAW_W-1:0];
  endfunction

  // Offer one request. The sender runs in bursts; between bursts it drops
  // valid for a random gap, except while the receiver holds off.
  task automatic send_request(input logic act, input logic [RAW_W-1:0] raw,
                              input logic typed, input climate_view_t want);
    int gap;
    climate_view_t shown;
    if (burst_left == 0 && !backlog_hold) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.action       = act;
    in_ch.humidity_raw = raw;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    shown = advance_climate(act, raw);
    climate_due.push_back(typed ? want : shown);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // Write one register; the predictor takes the value masked to its width
  task automatic write_reg(input cfg_addr_t idx, input logic [CDATA_W-1:0] val);
    cfg_ch.addr  = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_SHUTTER:  climate_cfg.shutter_thr  = val;
      CFG_FAN_LOW:  climate_cfg.fan_low_thr  = val;
      CFG_FAN_HIGH: climate_cfg.fan_high_thr = val;
      CFG_BAND:     climate_cfg.band         = val[BAND_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results;
    in_ch.valid = 1'b0;
    while (climate_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Score every accepted result against the oldest owed one
  always @(posedge clk) begin : score_results
    climate_view_t got;
    climate_view_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.shutter_is_open = out_ch.shutter_is_open;
      got.servo_compare   = out_ch.servo_compare;
      got.fan_drive_level = out_ch.fan_drive_level;
      got.fan_pin         = out_ch.fan_pin;
      results_seen++;
      if (climate_due.size() == 0) begin
        n_bad++;
        if (n_bad <= REPORT_MAX)
          $display("%0t: result with nothing owed: open=%0b servo=%0d level=%0d pin=%0b",
                   $time, got.shutter_is_open, got.servo_compare,
                   got.fan_drive_level, got.fan_pin);
      end else begin
        want = climate_due.pop_front();
        if (got.shutter_is_open !== want.shutter_is_open ||
            got.servo_compare   !== want.servo_compare ||
            got.fan_drive_level !== want.fan_drive_level ||
            got.fan_pin         !== want.fan_pin) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: result %0d: want open=%0b servo=%0d level=%0d pin=%0b",
                     $time, results_seen, want.shutter_is_open, want.servo_compare,
                     want.fan_drive_level, want.fan_pin,
                     ", got open=%0b servo=%0d level=%0d pin=%0b",
                     got.shutter_is_open, got.servo_compare,
                     got.fan_drive_level, got.fan_pin);
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves anything for too long
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, idle_cycles, climate_due.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: stall on its own pattern of modes, each for a random span.
  // Once, hold off for a long stretch so the block fills and stalls input.
  initial begin : result_sink
    int mode;
    int span_left;
    mode         = 0;
    span_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        backlog_hold = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        backlog_hold = 1'b0;
        hold_done    = 1'b1;
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 3);
        span_left = $urandom_range(8, 60);
      end
      span_left--;
      case (mode)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = ($urandom_range(0, 3) != 0);
        2:       out_ch.ready = ~out_ch.ready;
        default: out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int i;
    int p;
    int n;
    int pct;
    logic act;
    logic [RAW_W-1:0] raw;
    cfg_regs_t setting;

    // Drive every input to a known value before reset
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_CONTROL;
    in_ch.humidity_raw = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.addr        = CFG_SHUTTER;
    cfg_ch.data        = '0;
    rst_n              = 1'b0;
    climate_cfg = '{SHUTTER_RST, FAN_LOW_RST, FAN_HIGH_RST, BAND_RST};
    climate     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed script; register writes only once the block has gone quiet
    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        if (climate_due.size() != 0 || in_ch.valid) drain_results();
        write_reg(SCRIPT[i].addr, SCRIPT[i].data);
      end else begin
        send_request(SCRIPT[i].act, SCRIPT[i].raw, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end
    drain_results();

    // Random phases, each under its own threshold setting
    for (p = 0; p < PHASES; p++) begin
      if (p < 5) begin
        setting = FIXED_SETTINGS[p];
      end else begin
        setting.shutter_thr  = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(101, 127))
                                                            : PCT_W'($urandom_range(0, 100));
        setting.fan_low_thr  = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(101, 127))
                                                            : PCT_W'($urandom_range(0, 100));
        setting.fan_high_thr = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(101, 127))
                                                            : PCT_W'($urandom_range(0, 100));
        setting.band         = ($urandom_range(0, 5) == 0) ? BAND_W'($urandom_range(20, 31))
                                                            : BAND_W'($urandom_range(0, 19));
      end
      write_reg(CFG_SHUTTER, setting.shutter_thr);
      write_reg(CFG_FAN_LOW, setting.fan_low_thr);
      write_reg(CFG_FAN_HIGH, setting.fan_high_thr);
      write_reg(CFG_BAND, CDATA_W'(setting.band));
      n_settings++;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        act = ($urandom_range(0, 9) < 4) ? ACT_TICK : ACT_CONTROL;
        i   = $urandom_range(0, 9);
        if (i < 5) begin
          // hover around one of the five decision points
          case ($urandom_range(0, 4))
            0:       pct = int'(climate_cfg.shutter_thr);
            1:       pct = int'(climate_cfg.fan_low_thr);
            2:       pct = int'(climate_cfg.fan_high_thr);
            3:       pct = int'(climate_cfg.fan_low_thr) - int'(climate_cfg.band);
            default: pct = int'(climate_cfg.shutter_thr) - int'(climate_cfg.band);
          endcase
          raw = pct_to_raw(pct, int'($urandom_range(0, 8)) - 4);
        end else if (i < 8) begin
          // slow sweep up and down the whole range, like real humidity
          sweep_pct = sweep_pct + sweep_dir * int'($urandom_range(1, 4));
          if (sweep_pct >= 105) sweep_dir = -1;
          else if (sweep_pct <= -2) sweep_dir = 1;
          raw = pct_to_raw(sweep_pct, int'($urandom_range(0, 600)) - 300);
        end else if (i == 8) begin
          raw = RAW_W'($urandom);
        end else begin
          raw = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end
        send_request(act, raw, 1'b0, SHOW_NONE);
      end
      drain_results();
    end

    // Let the pipeline settle, then look for anything left owed
    repeat (6) @(posedge clk);
    if (climate_due.size() != 0) begin
      n_bad = n_bad + climate_due.size();
      $display("%0d results never arrived", climate_due.size());
    end

    $display("Ran %0d samples and %0d PWM ticks over %0d threshold settings plus the script.",
             n_samples, n_ticks, n_settings);
    $display("Checked %0d results: %0d fan startups, %0d shutter moves, %0d input stall cycles.",
             results_seen, n_startups, n_shutter_moves, in_stall_cycles);
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
